@@ src/rau_pkg.sv @@
// rau_pkg: command and status codes, result field widths and sideband structs
// for the rational arithmetic unit. No dependencies.
package rau_pkg;

	localparam logic [3:0] CMD_ADD = 4'd0;
	localparam logic [3:0] CMD_SUB = 4'd1;
	localparam logic [3:0] CMD_MUL = 4'd2;
	localparam logic [3:0] CMD_DIV = 4'd3;
	localparam logic [3:0] CMD_EQ  = 4'd4;
	localparam logic [3:0] CMD_NE  = 4'd5;
	localparam logic [3:0] CMD_LT  = 4'd6;
	localparam logic [3:0] CMD_GT  = 4'd7;
	localparam logic [3:0] CMD_LE  = 4'd8;
	localparam logic [3:0] CMD_GE  = 4'd9;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZDEN = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;

	localparam int RES_NUM_W = 33;
	localparam int RES_DEN_W = 31;
	localparam int OUT_DW    = 72;

	// sideband carried through operand reduction
	typedef struct packed {
		logic [3:0] cmd;
		logic       neg;
		logic       zden;
	} opnd_pay_t;

	// sideband carried through result reduction
	typedef struct packed {
		logic       neg;
		logic       cmp;
		logic [1:0] status;
		logic       arith;
	} res_pay_t;

endpackage

@@ src/rau_reduce.sv @@
// rau_reduce: pipelined fraction reduction, binary gcd one step per stage,
// then restoring division of both parts by the gcd, one quotient bit per stage.
// Depends on nothing; sideband is an opaque vector.
module rau_reduce #(
	parameter int N  = 16,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          in_valid,
	input  logic [N-1:0]  in_n,
	input  logic [N-1:0]  in_d,
	input  logic [PW-1:0] in_pay,
	output logic          out_valid,
	output logic [N-1:0]  out_n,
	output logic [N-1:0]  out_d,
	output logic [PW-1:0] out_pay
);

	localparam int G  = 2 * N;
	localparam int KW = $clog2(N + 1);

	// gcd stages
	logic [N-1:0]  gu_s [G+1];
	logic [N-1:0]  gv_s [G+1];
	logic [KW-1:0] gk_s [G+1];
	logic [N-1:0]  gn_s [G+1];
	logic [N-1:0]  gd_s [G+1];
	logic          gval_s [G+1];
	logic [PW-1:0] gpay_s [G+1];

	logic [N-1:0]  nu [G];
	logic [N-1:0]  nv [G];
	logic [KW-1:0] nk [G];

	// division stages
	logic [N-1:0]  dg_s  [N+1];
	logic [N-1:0]  dxn_s [N+1];
	logic [N-1:0]  dxd_s [N+1];
	logic [N-1:0]  drn_s [N+1];
	logic [N-1:0]  drd_s [N+1];
	logic [N-1:0]  dqn_s [N+1];
	logic [N-1:0]  dqd_s [N+1];
	logic          dval_s [N+1];
	logic [PW-1:0] dpay_s [N+1];

	logic [N:0] sn [N];
	logic [N:0] sd [N];

	// {quotient bit, new remainder}
	function automatic logic [N:0] div_step(input logic [N-1:0] r, input logic b,
		input logic [N-1:0] g);
		logic [N:0] t;
		t = {r, b};
		if (t >= {1'b0, g})
			return {1'b1, N'(t - {1'b0, g})};
		return {1'b0, t[N-1:0]};
	endfunction

	always_comb begin
		for (int i = 0; i < G; i++) begin
			nu[i] = gu_s[i];
			nv[i] = gv_s[i];
			nk[i] = gk_s[i];
			if (gu_s[i] != '0 && gv_s[i] != '0) begin
				priority if (!gu_s[i][0] && !gv_s[i][0]) begin
					nu[i] = gu_s[i] >> 1;
					nv[i] = gv_s[i] >> 1;
					nk[i] = KW'(gk_s[i] + 1'b1);
				end else if (!gu_s[i][0]) begin
					nu[i] = gu_s[i] >> 1;
				end else if (!gv_s[i][0]) begin
					nv[i] = gv_s[i] >> 1;
				end else if (gu_s[i] >= gv_s[i]) begin
					nu[i] = (gu_s[i] - gv_s[i]) >> 1;
				end else begin
					nv[i] = (gv_s[i] - gu_s[i]) >> 1;
				end
			end
		end
		for (int j = 0; j < N; j++) begin
			sn[j] = div_step(drn_s[j], dxn_s[j][N-1], dg_s[j]);
			sd[j] = div_step(drd_s[j], dxd_s[j][N-1], dg_s[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= G; i++) gval_s[i] <= 1'b0;
			for (int j = 0; j <= N; j++) dval_s[j] <= 1'b0;
		end else if (adv) begin
			gval_s[0] <= in_valid;
			for (int i = 0; i < G; i++) gval_s[i+1] <= gval_s[i];
			dval_s[0] <= gval_s[G];
			for (int j = 0; j < N; j++) dval_s[j+1] <= dval_s[j];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gu_s[0]   <= in_n;
			gv_s[0]   <= in_d;
			gk_s[0]   <= '0;
			gn_s[0]   <= in_n;
			gd_s[0]   <= in_d;
			gpay_s[0] <= in_pay;
			for (int i = 0; i < G; i++) begin
				gu_s[i+1]   <= nu[i];
				gv_s[i+1]   <= nv[i];
				gk_s[i+1]   <= nk[i];
				gn_s[i+1]   <= gn_s[i];
				gd_s[i+1]   <= gd_s[i];
				gpay_s[i+1] <= gpay_s[i];
			end
			// gcd = odd part restored by the common power of two
			dg_s[0]   <= (gu_s[G] | gv_s[G]) << gk_s[G];
			dxn_s[0]  <= gn_s[G];
			dxd_s[0]  <= gd_s[G];
			drn_s[0]  <= '0;
			drd_s[0]  <= '0;
			dqn_s[0]  <= '0;
			dqd_s[0]  <= '0;
			dpay_s[0] <= gpay_s[G];
			for (int j = 0; j < N; j++) begin
				dg_s[j+1]   <= dg_s[j];
				dxn_s[j+1]  <= {dxn_s[j][N-2:0], 1'b0};
				dxd_s[j+1]  <= {dxd_s[j][N-2:0], 1'b0};
				drn_s[j+1]  <= sn[j][N-1:0];
				drd_s[j+1]  <= sd[j][N-1:0];
				dqn_s[j+1]  <= {dqn_s[j][N-2:0], sn[j][N]};
				dqd_s[j+1]  <= {dqd_s[j][N-2:0], sd[j][N]};
				dpay_s[j+1] <= dpay_s[j];
			end
		end
	end

	assign out_valid = dval_s[N];
	assign out_n     = dqn_s[N];
	assign out_d     = dqd_s[N];
	assign out_pay   = dpay_s[N];

endmodule

@@ src/rational_arith_unit_top.sv @@
// rational_arith_unit_top: signed fraction add/sub/mul/div and compare with
// gcd reduction. Depends on rau_pkg and rau_reduce.
//
// Usage:
//   Slave channel s_*: one transaction per operation. s_tuser carries cmd,
//   s_tdata carries a_num, a_den, b_num, b_den (WIDTH bits each).
//   Master channel m_*: one result transaction per input transaction, in order.
//   m_tdata carries res_num, res_den, cmp_true; m_tuser carries status.
// Pipeline: input register, operand reduction, cross products, select, result
//   reduction, output register; each reduction pipeline has 3*N+2 stages for a
//   binary gcd (one step per stage) followed by restoring division (one bit per
//   stage), N being WIDTH for the operands and 2*WIDTH for the result.
// Throughput: one transaction per cycle unless stalled; all stages registered.
// Reset: arst_n clears all valid bits; the pipeline comes up empty.
// Stall: when m_tvalid is high and m_tready low the whole pipeline holds,
//   s_tready drops, and nothing is lost or repeated.
// Zero denominators give status 1, division by a zero fraction status 2;
// both return 0/1 with cmp_true low.
module rational_arith_unit_top #(
	parameter int WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// a_num, a_den, b_num, b_den from bit 0 up, zero padded to bytes
	input  logic [((4*WIDTH+7)/8)*8-1:0] s_tdata,
	// cmd
	input  logic [3:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// res_num[32:0], res_den[63:33], cmp_true[64], zero padding above
	output logic [rau_pkg::OUT_DW-1:0] m_tdata,
	// status
	output logic [1:0] m_tuser
);
	import rau_pkg::*;

	localparam int RW   = 2 * WIDTH;
	localparam int XN   = (RW + 1 > RES_NUM_W) ? RW + 1 : RES_NUM_W;
	localparam int XD   = (RW > RES_DEN_W) ? RW : RES_DEN_W;
	localparam int PADW = OUT_DW - RES_NUM_W - RES_DEN_W - 1;
	localparam int PA_W = $bits(opnd_pay_t);
	localparam int PR_W = $bits(res_pay_t);

	// whole pipeline advances unless a finished result is stuck
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// sign / magnitude of a two's complement field
	function automatic logic [WIDTH:0] to_sm(input logic [WIDTH-1:0] raw);
		return {raw[WIDTH-1], raw[WIDTH-1] ? (~raw + 1'b1) : raw};
	endfunction

	logic [WIDTH:0] an_c, ad_c, bn_c, bd_c;
	assign an_c = to_sm(s_tdata[0 +: WIDTH]);
	assign ad_c = to_sm(s_tdata[WIDTH +: WIDTH]);
	assign bn_c = to_sm(s_tdata[2*WIDTH +: WIDTH]);
	assign bd_c = to_sm(s_tdata[3*WIDTH +: WIDTH]);

	// stage 1: input register, sign-magnitude split
	logic             val_s1;
	logic [3:0]       cmd_s1;
	logic [WIDTH-1:0] an_s1, ad_s1, bn_s1, bd_s1;
	logic             sa_s1, sb_s1, zden_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
		end else if (adv) begin
			val_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1  <= s_tuser;
			an_s1   <= an_c[WIDTH-1:0];
			ad_s1   <= ad_c[WIDTH-1:0];
			bn_s1   <= bn_c[WIDTH-1:0];
			bd_s1   <= bd_c[WIDTH-1:0];
			sa_s1   <= an_c[WIDTH] ^ ad_c[WIDTH];
			sb_s1   <= bn_c[WIDTH] ^ bd_c[WIDTH];
			zden_s1 <= (ad_c[WIDTH-1:0] == '0) || (bd_c[WIDTH-1:0] == '0);
		end
	end

	// operand reduction, one lane per fraction
	opnd_pay_t        pa_in, pa_out;
	logic [PA_W-1:0]  oa_pay;
	logic [0:0]       ob_pay;
	logic             oa_valid, ob_valid;
	logic [WIDTH-1:0] oa_n, oa_d, ob_n, ob_d;

	assign pa_in = '{cmd: cmd_s1, neg: sa_s1, zden: zden_s1};

	rau_reduce #(.N(WIDTH), .PW(PA_W)) u_red_a (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(val_s1),
		.in_n(an_s1), .in_d(ad_s1), .in_pay(pa_in),
		.out_valid(oa_valid), .out_n(oa_n), .out_d(oa_d), .out_pay(oa_pay)
	);

	rau_reduce #(.N(WIDTH), .PW(1)) u_red_b (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(val_s1),
		.in_n(bn_s1), .in_d(bd_s1), .in_pay(sb_s1),
		.out_valid(ob_valid), .out_n(ob_n), .out_d(ob_d), .out_pay(ob_pay)
	);

	assign pa_out = opnd_pay_t'(oa_pay);

	// stage 2: cross products
	logic          val_s2, zden_s2, aneg_s2, bneg_s2, bnz_s2, eq_s2;
	logic [3:0]    cmd_s2;
	logic [RW-1:0] p_s2, q_s2, nn_s2, dd_s2;
	logic          aneg_c, bneg_c;
	logic [RW-1:0] p_c, q_c, nn_c, dd_c;

	assign aneg_c = pa_out.neg && (oa_n != '0);
	assign bneg_c = ob_pay[0] && (ob_n != '0);
	assign p_c    = oa_n * ob_d;
	assign q_c    = ob_n * oa_d;
	assign nn_c   = oa_n * ob_n;
	assign dd_c   = oa_d * ob_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s2 <= 1'b0;
		end else if (adv) begin
			val_s2 <= oa_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2  <= pa_out.cmd;
			zden_s2 <= pa_out.zden;
			aneg_s2 <= aneg_c;
			bneg_s2 <= bneg_c;
			bnz_s2  <= (ob_n != '0);
			eq_s2   <= (aneg_c == bneg_c) && (oa_n == ob_n) && (oa_d == ob_d);
			p_s2    <= p_c;
			q_s2    <= q_c;
			nn_s2   <= nn_c;
			dd_s2   <= dd_c;
		end
	end

	// stage 3: signed add, compare, command select
	logic          qn_c, sg_c, lt_c, gt_c, eqm_c;
	logic [RW-1:0] mag_c, rn_c, rd_c;
	res_pay_t      rp_c;

	always_comb begin
		qn_c = (cmd_s2 == CMD_SUB) ? !bneg_s2 : bneg_s2;
		priority if (aneg_s2 == qn_c) begin
			mag_c = p_s2 + q_s2;
			sg_c  = aneg_s2;
		end else if (p_s2 >= q_s2) begin
			mag_c = p_s2 - q_s2;
			sg_c  = aneg_s2;
		end else begin
			mag_c = q_s2 - p_s2;
			sg_c  = qn_c;
		end
		// ordering on cross products, signs already zero-clean
		eqm_c = (aneg_s2 == bneg_s2) && (p_s2 == q_s2);
		lt_c  = (aneg_s2 && !bneg_s2) ||
			((aneg_s2 == bneg_s2) && (aneg_s2 ? (p_s2 > q_s2) : (p_s2 < q_s2)));
		gt_c  = !lt_c && !eqm_c;

		rn_c = '0;
		rd_c = RW'(1);
		rp_c = '{neg: 1'b0, cmp: 1'b0, status: ST_OK, arith: 1'b0};
		unique case (cmd_s2)
			CMD_ADD, CMD_SUB: begin
				rn_c = mag_c;
				rd_c = dd_s2;
				rp_c.neg = sg_c;
				rp_c.arith = 1'b1;
			end
			CMD_MUL: begin
				rn_c = nn_s2;
				rd_c = dd_s2;
				rp_c.neg = aneg_s2 ^ bneg_s2;
				rp_c.arith = 1'b1;
			end
			CMD_DIV: begin
				if (bnz_s2) begin
					rn_c = p_s2;
					rd_c = q_s2;
					rp_c.neg = aneg_s2 ^ bneg_s2;
					rp_c.arith = 1'b1;
				end else begin
					rp_c.status = ST_DIVZ;
				end
			end
			CMD_EQ: rp_c.cmp = eq_s2;
			CMD_NE: rp_c.cmp = !eq_s2;
			CMD_LT: rp_c.cmp = lt_c;
			CMD_GT: rp_c.cmp = gt_c;
			CMD_LE: rp_c.cmp = !gt_c;
			CMD_GE: rp_c.cmp = !lt_c;
			default: ;
		endcase
		if (zden_s2) begin
			rn_c = '0;
			rd_c = RW'(1);
			rp_c = '{neg: 1'b0, cmp: 1'b0, status: ST_ZDEN, arith: 1'b0};
		end
	end

	logic          val_s3;
	logic [RW-1:0] rn_s3, rd_s3;
	res_pay_t      rp_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s3 <= 1'b0;
		end else if (adv) begin
			val_s3 <= val_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rn_s3 <= rn_c;
			rd_s3 <= rd_c;
			rp_s3 <= rp_c;
		end
	end

	// result reduction at double width
	logic            or_valid;
	logic [RW-1:0]   or_n, or_d;
	logic [PR_W-1:0] or_pay;
	res_pay_t        rp_out;

	rau_reduce #(.N(RW), .PW(PR_W)) u_red_r (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(val_s3),
		.in_n(rn_s3), .in_d(rd_s3), .in_pay(rp_s3),
		.out_valid(or_valid), .out_n(or_n), .out_d(or_d), .out_pay(or_pay)
	);

	assign rp_out = res_pay_t'(or_pay);

	// stage 4: output register, sign applied, fit to field widths
	logic                 neg_c;
	logic signed [RW:0]   sv_c;
	logic signed [XN-1:0] xn_c;
	logic [XD-1:0]        xd_c;

	assign neg_c = rp_out.neg && (or_n != '0);
	assign sv_c  = neg_c ? -signed'({1'b0, or_n}) : signed'({1'b0, or_n});
	assign xn_c  = XN'(sv_c);
	assign xd_c  = XD'(or_d);

	logic                 val_s4, cmp_s4;
	logic [RES_NUM_W-1:0] num_s4;
	logic [RES_DEN_W-1:0] den_s4;
	logic [1:0]           st_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s4 <= 1'b0;
		end else if (adv) begin
			val_s4 <= or_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s4 <= rp_out.arith ? xn_c[RES_NUM_W-1:0] : '0;
			den_s4 <= rp_out.arith ? xd_c[RES_DEN_W-1:0] : RES_DEN_W'(1);
			cmp_s4 <= rp_out.cmp;
			st_s4  <= rp_out.status;
		end
	end

	assign m_tvalid = val_s4;
	assign m_tdata  = {{PADW{1'b0}}, cmp_s4, den_s4, num_s4};
	assign m_tuser  = st_s4;

	// both operand lanes run in lockstep
	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		oa_valid == ob_valid)
		else $error("operand reduction lanes out of step");

	// a flagged result carries numerator 0 and no compare outcome
	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_OK) |->
		(m_tdata[RES_NUM_W-1:0] == '0) && (m_tdata[RES_NUM_W+RES_DEN_W] == 1'b0))
		else $error("flagged result not zero");

	// a true compare outcome never comes with an arithmetic result or a flag
	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		or_valid && rp_out.cmp |-> !rp_out.arith && (rp_out.status == ST_OK))
		else $error("compare outcome on arithmetic result");

endmodule
